// ----- src/uat_pkg.sv -----
// Shared types and constants for the unordered array table.
// Used by the storage cell, the top level and the port checker.
`default_nettype none

package uat_pkg;

  // Field widths
  localparam int CMD_W = 2;
  localparam int VAL_W = 32;
  localparam int IDX_W = 5;
  localparam int CNT_W = 5;
  localparam int CAP_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam logic [IDX_W-1:0] IDX_NONE  = 5'h1F;

  // Command codes; the fourth code is a no-op
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_FIND   = 2'd2
  } cmd_t;

  // Control broadcast from the sequencer to every cell
  typedef struct packed {
    logic load_hit;  // latch compare result for the incoming transaction
    logic shift;     // close the gap behind the first hit
    logic write;     // append the operand at the slot equal to the count
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- src/unordered_array_table_top.sv -----
// Top level of the unordered array table: sequencer, count, and the chain of cells.
// Depends on uat_pkg and uat_cell.
`default_nettype none

// A packed table of signed 32-bit words held in a row of DEPTH cells. Each
// transaction carries one command: insert appends at the fill point if the
// count is below min(capacity, DEPTH); remove deletes the first equal entry
// and shifts later entries down; find reports the first equal slot. A result
// gives success, the matching slot (-1 for none or for insert, low five bits
// of the slot) and the count afterward (low five bits). Every cell compares
// its entry at the edge that accepts the transaction; the next cycle resolves
// the first hit along the chain, and the update commits together with the
// result register once out_stall no longer holds a waiting result. A new
// transaction is accepted while a finished result still waits. Capacity is
// written through cfg_we and cfg_wdata; the user must write it only while
// the block is idle, which the block itself does not enforce. It resets to 16.
// Entries have no reset; only slots below the count are ever read.

module unordered_array_table_top #(
  parameter int DEPTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic        [uat_pkg::CMD_W-1:0] in_command,
  input  wire logic signed [uat_pkg::VAL_W-1:0] in_operand_value,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  out_success,
  output logic signed      [uat_pkg::IDX_W-1:0] out_match_index,
  output logic             [uat_pkg::CNT_W-1:0] out_fill_count,
  input  wire logic                             cfg_we,
  input  wire logic        [uat_pkg::CAP_W-1:0] cfg_wdata
);
  import uat_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int MW = (CW > CAP_W) ? CW : CAP_W;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t             state_r;
  logic [CAP_W-1:0]   cap_r;
  logic [CW-1:0]      count_r;
  logic [CW-1:0]      count_nxt;
  logic [CMD_W-1:0]   op_r;
  logic [VAL_W-1:0]   operand_r;
  logic               out_valid_r;
  logic               out_success_r;
  logic [IDX_W-1:0]   out_index_r;
  logic [CNT_W-1:0]   out_count_r;

  logic               in_accept;
  logic               finish;
  logic               ins_ok;
  logic               found;
  logic               success;
  logic [IDX_W-1:0]   index_out;
  logic [IW-1:0]      first_idx;
  logic [IW+4:0]      idx_wide;
  logic [CW+4:0]      cnt_wide;
  cell_ctl_t          ctl;

  logic [VAL_W-1:0]   entry_w [DEPTH];
  logic [DEPTH:0]     hit_chain;
  logic [DEPTH-1:0]   first_w;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign finish    = (state_r == S_EXEC) && (!out_valid_r || !out_stall);

  // Capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  // Cell chain
  assign hit_chain[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VAL_W-1:0] next_w;
    if (i == DEPTH - 1) begin : g_tail
      assign next_w = entry_w[i];
    end else begin : g_body
      assign next_w = entry_w[i+1];
    end
    uat_cell #(
      .INDEX (i),
      .CW    (CW)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .count      (count_r),
      .cmp_value  (in_operand_value),
      .wr_value   (operand_r),
      .next_entry (next_w),
      .hit_before (hit_chain[i]),
      .entry      (entry_w[i]),
      .hit_upto   (hit_chain[i+1]),
      .first_hit  (first_w[i])
    );
  end

  assign found = hit_chain[DEPTH];

  // Encode the one-hot first hit into a slot number
  always_comb begin
    first_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first_w[i]) begin
        first_idx = first_idx | IW'(i);
      end
    end
  end

  assign idx_wide = (IW + 5)'(first_idx);
  assign ins_ok   = (MW'(count_r) < MW'(cap_r)) && (count_r < CW'(DEPTH));

  // Resolve the command
  always_comb begin
    ctl.load_hit = in_accept;
    ctl.shift    = 1'b0;
    ctl.write    = 1'b0;
    success      = 1'b0;
    index_out    = IDX_NONE;
    count_nxt    = count_r;
    unique case (cmd_t'(op_r))
      CMD_INSERT: begin
        success   = ins_ok;
        ctl.write = finish && ins_ok;
        if (ins_ok) begin
          count_nxt = count_r + CW'(1);
        end
      end
      CMD_REMOVE: begin
        success   = found;
        ctl.shift = finish && found;
        if (found) begin
          index_out = idx_wide[IDX_W-1:0];
          count_nxt = count_r - CW'(1);
        end
      end
      CMD_FIND: begin
        success = found;
        if (found) begin
          index_out = idx_wide[IDX_W-1:0];
        end
      end
      default: begin
        success = 1'b0;
      end
    endcase
  end

  assign cnt_wide = (CW + 5)'(count_nxt);

  // Sequencer, count and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && !finish) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            op_r      <= in_command;
            operand_r <= in_operand_value;
            state_r   <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (finish) begin
            count_r       <= count_nxt;
            out_valid_r   <= 1'b1;
            out_success_r <= success;
            out_index_r   <= index_out;
            out_count_r   <= cnt_wide[CNT_W-1:0];
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_success     = out_success_r;
  assign out_match_index = out_index_r;
  assign out_fill_count  = out_count_r;

endmodule

`default_nettype wire

// ----- src/uat_cell.sv -----
// One slot of the table: holds an entry, compares it, and shifts from its neighbor.
// Depends on uat_pkg for widths and the control struct.
`default_nettype none

module uat_cell #(
  parameter int INDEX = 0,
  parameter int CW    = 5
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire uat_pkg::cell_ctl_t        ctl,
  input  wire logic [CW-1:0]             count,
  input  wire logic [uat_pkg::VAL_W-1:0] cmp_value,
  input  wire logic [uat_pkg::VAL_W-1:0] wr_value,
  input  wire logic [uat_pkg::VAL_W-1:0] next_entry,
  input  wire logic                      hit_before,
  output logic      [uat_pkg::VAL_W-1:0] entry,
  output logic                           hit_upto,
  output logic                           first_hit
);
  import uat_pkg::*;

  logic [VAL_W-1:0] entry_r;
  logic             hit_r;
  logic             occupied;

  assign occupied  = CW'(INDEX) < count;
  assign hit_upto  = hit_before | hit_r;
  assign first_hit = hit_r & ~hit_before;
  assign entry     = entry_r;

  // Latch the compare result when a transaction enters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (ctl.load_hit) begin
      hit_r <= occupied && (entry_r == cmp_value);
    end
  end

  // Append at the fill point, or take the neighbor's entry behind the first hit
  always_ff @(posedge clk) begin
    if (ctl.write && (count == CW'(INDEX))) begin
      entry_r <= wr_value;
    end else if (ctl.shift && hit_upto) begin
      entry_r <= next_entry;
    end
  end

endmodule

`default_nettype wire

// ----- src/uat_checker.sv -----
// Port-level checker for the unordered array table, bound to the top level.
// Depends on uat_pkg and unordered_array_table_top.
`default_nettype none

module uat_checker #(
  parameter int DEPTH = 16
) (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_valid,
  input wire logic                             in_stall,
  input wire logic                             out_valid,
  input wire logic                             out_stall,
  input wire logic                             out_success,
  input wire logic signed [uat_pkg::IDX_W-1:0] out_match_index,
  input wire logic        [uat_pkg::CNT_W-1:0] out_fill_count
);
  import uat_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_success)
      && $stable(out_match_index) && $stable(out_fill_count))
    else $error("stalled result changed");

  // A failed transaction reports no slot
  a_fail_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_success |-> out_match_index == IDX_NONE)
    else $error("failed transaction reports a slot");

  // Count never exceeds the built depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (DEPTH >= 32) || (int'(out_fill_count) <= DEPTH))
    else $error("fill count above depth");

  // One transaction in flight: stall the input right after an accept
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction accepted while busy");

endmodule

bind unordered_array_table_top uat_checker #(.DEPTH(DEPTH)) u_uat_checker (.*);

`default_nettype wire

// ----- bench/unordered_array_table_top_tb.sv -----
// Self-checking testbench for the unordered array table: directed, capacity,
// back-pressure and random command traffic checked against a shadow table.
// Depends on uat_pkg and unordered_array_table_top.

module unordered_array_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import uat_pkg::*;

  localparam int TABLE_DEPTH  = 16;
  localparam int IDLE_PCT     = 28;
  localparam int HOLD_CYCLES  = 60;
  localparam int SETTLE_CYCLES = 4;
  localparam int REPORT_LIMIT = 40;
  localparam int POOL_SIZE    = 8;

  // Unused fourth command code: the block treats it as a no-op
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic             success;
    logic [IDX_W-1:0] slot;
    logic [CNT_W-1:0] fill;
  } table_outcome_t;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [CMD_W-1:0]         in_command;
  logic signed [VAL_W-1:0]  in_operand_value;
  logic                     out_valid;
  logic                     out_stall;
  logic                     out_success;
  logic signed [IDX_W-1:0]  out_match_index;
  logic [CNT_W-1:0]         out_fill_count;
  logic                     cfg_we;
  logic [CAP_W-1:0]         cfg_wdata;

  // Shadow of the block's contents and its capacity register
  logic signed [VAL_W-1:0]  shadow_table[$];
  logic [CAP_W-1:0]         shadow_capacity;
  table_outcome_t           awaited_outcomes[$];
  logic signed [VAL_W-1:0]  value_pool[POOL_SIZE];

  int error_count = 0;
  bit steady_mode = 1'b0;
  bit hold_request = 1'b0;

  unordered_array_table_top #(
    .DEPTH(TABLE_DEPTH)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_operand_value (in_operand_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_success      (out_success),
    .out_match_index  (out_match_index),
    .out_fill_count   (out_fill_count),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Apply one command to the shadow table and return the outcome it yields
  function automatic table_outcome_t model_command(input logic [CMD_W-1:0] cmd,
                                                   input logic signed [VAL_W-1:0] val);
    table_outcome_t res;
    int hit;
    int usable;
    res.success = 1'b0;
    res.slot    = IDX_NONE;
    hit = -1;
    foreach (shadow_table[i])
      if (hit < 0 && shadow_table[i] == val) hit = i;
    // capacity saturates at the built depth; zero means always full
    usable = (shadow_capacity > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_capacity);
    case (cmd)
      CMD_INSERT: begin
        if (shadow_table.size() < usable) begin
          shadow_table.push_back(val);
          res.success = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (hit >= 0) begin
          shadow_table.delete(hit);
          res.success = 1'b1;
          res.slot    = IDX_W'(hit);
        end
      end
      CMD_FIND: begin
        if (hit >= 0) begin
          res.success = 1'b1;
          res.slot    = IDX_W'(hit);
        end
      end
      default: ;
    endcase
    res.fill = CNT_W'(shadow_table.size());
    return res;
  endfunction

  // Predict at every accepted input transaction
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      awaited_outcomes.push_back(model_command(in_command, in_operand_value));
  end

  task automatic report_field(input string field, input int want, input int got);
    error_count++;
    if (error_count <= REPORT_LIMIT)
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  // Compare every accepted result with the oldest outcome due
  always @(posedge clk) begin : check_outcomes
    table_outcome_t due;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_outcomes.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT)
          $display("%0t ns: unexpected result, expected none, actual %0b/%0d/%0d", $time,
                   out_success, out_match_index, out_fill_count);
      end else begin
        due = awaited_outcomes.pop_front();
        if (out_success !== due.success)
          report_field("success", due.success, out_success);
        if (out_match_index !== $signed(due.slot))
          report_field("match_index", $signed(due.slot), out_match_index);
        if (out_fill_count !== due.fill)
          report_field("fill_count", due.fill, out_fill_count);
      end
    end
  end

  // Receiver: random stalls, a steady mode, and a long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_request = 1'b0;
      end else begin
        out_stall <= !steady_mode && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Offer one transaction after a random gap and hold it until accepted
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic signed [VAL_W-1:0] val);
    int gap;
    gap = 0;
    if (!steady_mode)
      while ($urandom_range(99) < IDLE_PCT && gap < 16) gap += $urandom_range(1, 2);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_command       <= cmd;
    in_operand_value <= val;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait until every outcome has been checked
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    wait_idle();
    cfg_wdata <= cap;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_capacity = cap;
  endtask

  // Remove every entry currently held
  task automatic empty_table();
    logic signed [VAL_W-1:0] held[$];
    wait_idle();
    held = shadow_table;
    foreach (held[i]) send_item(CMD_REMOVE, held[i]);
  endtask

  task automatic refresh_pool();
    foreach (value_pool[i]) value_pool[i] = $urandom;
    // keep the extremes and zero in play now and then
    if ($urandom_range(3) == 0) value_pool[0] = VAL_MIN;
    if ($urandom_range(3) == 0) value_pool[1] = VAL_MAX;
    if ($urandom_range(3) == 0) value_pool[2] = '0;
  endtask

  // Mostly pool values so that finds and removes hit; some fresh noise
  task automatic send_random_item();
    logic [CMD_W-1:0] cmd;
    logic signed [VAL_W-1:0] val;
    int pick;
    pick = $urandom_range(99);
    if (pick < 42)      cmd = CMD_INSERT;
    else if (pick < 65) cmd = CMD_REMOVE;
    else if (pick < 95) cmd = CMD_FIND;
    else                cmd = CMD_NOP;
    if ($urandom_range(99) < 85) val = value_pool[$urandom_range(POOL_SIZE - 1)];
    else                         val = $urandom;
    send_item(cmd, val);
  endtask

  task automatic test_directed_ops();
    // empty table: nothing to find or remove
    send_item(CMD_FIND, '0);
    send_item(CMD_REMOVE, 32'sd5);
    // extremes, zero, minus one and a duplicate pair
    send_item(CMD_INSERT, VAL_MIN);
    send_item(CMD_INSERT, VAL_MAX);
    send_item(CMD_INSERT, '0);
    send_item(CMD_INSERT, -32'sd1);
    send_item(CMD_INSERT, 32'sd7);
    send_item(CMD_INSERT, 32'sd7);
    send_item(CMD_FIND, 32'sd7);
    send_item(CMD_FIND, VAL_MIN);
    send_item(CMD_FIND, VAL_MAX);
    send_item(CMD_FIND, 32'sd12345);
    // remove from the middle, then the head; later entries shift down
    send_item(CMD_REMOVE, '0);
    send_item(CMD_FIND, 32'sd7);
    send_item(CMD_REMOVE, VAL_MIN);
    send_item(CMD_REMOVE, 32'sd7);
    send_item(CMD_FIND, 32'sd7);
    send_item(CMD_NOP, 32'sd7);
    send_item(CMD_REMOVE, 32'sd7);
    // remove the tail, then drain and miss
    send_item(CMD_REMOVE, -32'sd1);
    send_item(CMD_REMOVE, VAL_MAX);
    send_item(CMD_REMOVE, VAL_MAX);
    send_item(CMD_FIND, -32'sd1);
  endtask

  task automatic test_capacity_limits();
    logic signed [VAL_W-1:0] vals[TABLE_DEPTH + 2];
    empty_table();
    // capacity one: second insert fails
    write_capacity(5'd1);
    send_item(CMD_INSERT, 32'sd11);
    send_item(CMD_INSERT, 32'sd12);
    send_item(CMD_FIND, 32'sd11);
    // capacity zero: always full, held entries stay searchable
    write_capacity(5'd0);
    send_item(CMD_INSERT, 32'sd13);
    send_item(CMD_FIND, 32'sd11);
    send_item(CMD_REMOVE, 32'sd11);
    send_item(CMD_INSERT, 32'sd13);
    // capacity above the depth saturates at the depth
    write_capacity(5'd31);
    foreach (vals[i]) begin
      vals[i] = $urandom;
      send_item(CMD_INSERT, vals[i]);
    end
    send_item(CMD_FIND, vals[TABLE_DEPTH - 1]);
    // capacity lowered below the count: keep entries, refuse inserts
    write_capacity(5'd3);
    send_item(CMD_INSERT, 32'sd21);
    for (int i = TABLE_DEPTH - 1; i >= 3; i--) send_item(CMD_REMOVE, vals[i]);
    send_item(CMD_INSERT, 32'sd22);
    send_item(CMD_REMOVE, vals[0]);
    send_item(CMD_INSERT, 32'sd23);
    write_capacity(5'd17);
    send_item(CMD_INSERT, 32'sd24);
    empty_table();
    write_capacity(5'd16);
  endtask

  // Neither side idles for a long stretch
  task automatic test_steady_stream();
    refresh_pool();
    wait_idle();
    steady_mode = 1'b1;
    repeat (60) send_random_item();
    wait_idle();
    steady_mode = 1'b0;
  endtask

  // Hold the receiver off while the sender keeps offering, then release it
  task automatic test_backpressure();
    refresh_pool();
    wait_idle();
    steady_mode  = 1'b1;
    hold_request = 1'b1;
    repeat (24) send_random_item();
    wait_idle();
    steady_mode = 1'b0;
  endtask

  task automatic test_random_traffic(input int n_items);
    int sent;
    int pick;
    int phase_len;
    sent = 0;
    while (sent < n_items) begin
      // new capacity per phase, mostly legal, sometimes zero or oversize
      pick = $urandom_range(99);
      if (pick < 8)       write_capacity(5'd0);
      else if (pick < 18) write_capacity(CAP_W'($urandom_range(17, 31)));
      else                write_capacity(CAP_W'($urandom_range(1, 16)));
      refresh_pool();
      phase_len = $urandom_range(40, 80);
      repeat (phase_len) send_random_item();
      sent += phase_len;
    end
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_command       <= CMD_INSERT;
    in_operand_value <= '0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= CAP_RESET;
    shadow_capacity  = CAP_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_ops();
    test_capacity_limits();
    test_steady_stream();
    test_backpressure();
    test_random_traffic(340);

    wait_idle();
    repeat (8) @(posedge clk);
    if (error_count == 0 && awaited_outcomes.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
